### rtl/core/terminal_escape_key_decoder_assert.svh
// Assertion macros for the terminal escape key decoder.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TEKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TEKD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TEKD_ASSERT(lbl, prop, msg)
`define TEKD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/tekd_pkg.sv
// Shared types, codes and the key decode function for the terminal escape key decoder.
// No dependencies.
package tekd_pkg;

  typedef enum logic [1:0] {
    MODE_DATA = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_END  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_PLAIN = 2'd0,
    ST_ESC   = 2'd1,
    ST_PARAM = 2'd2,
    ST_INTER = 2'd3
  } parse_state_t;

  localparam logic [7:0] ESC_CODE    = 8'd27;
  localparam logic [7:0] CHR_LBRACK  = 8'h5B;
  localparam logic [7:0] CHR_TILDE   = 8'h7E;
  localparam logic [7:0] CHR_ONE     = 8'h31;
  localparam logic [7:0] CHR_SIX     = 8'h36;
  localparam logic [7:0] CHR_UP      = 8'h41;
  localparam logic [7:0] CHR_DOWN    = 8'h42;
  localparam logic [7:0] CHR_RIGHT   = 8'h43;
  localparam logic [7:0] CHR_LEFT    = 8'h44;
  localparam logic [7:0] CHR_END     = 8'h46;
  localparam logic [7:0] CHR_HOME    = 8'h48;
  localparam logic [7:0] PARAM_LO    = 8'h30;
  localparam logic [7:0] PARAM_HI    = 8'h3F;
  localparam logic [7:0] INTER_LO    = 8'h20;
  localparam logic [7:0] INTER_HI    = 8'h2F;
  localparam logic [7:0] PRINT_LO    = 8'd32;
  localparam logic [7:0] PRINT_HI    = 8'd127;
  localparam logic [7:0] CTRL_HI     = 8'd26;
  localparam logic [7:0] IDLE_MAX    = 8'd255;
  localparam logic [7:0] IDLE_TICKS_RESET = 8'd2;

  localparam logic [3:0] KC_NONE  = 4'd0;
  localparam logic [3:0] KC_UP    = 4'd1;
  localparam logic [3:0] KC_DOWN  = 4'd2;
  localparam logic [3:0] KC_RIGHT = 4'd3;
  localparam logic [3:0] KC_LEFT  = 4'd4;
  localparam logic [3:0] KC_HOME  = 4'd5;
  localparam logic [3:0] KC_END   = 4'd8;

  typedef struct packed {
    logic [3:0] key_code;
    logic [6:0] char_code;
    logic       pressed;
  } key_event_t;

  function automatic key_event_t decode_keys(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
    key_event_t ev;
    logic [7:0] tilde_ofs;
    ev = '0;
    tilde_ofs = b2 - CHR_ONE;
    if ((b0 >= PRINT_LO && b0 <= PRINT_HI) || (b0 >= 8'd1 && b0 <= CTRL_HI)) begin
      ev.pressed = 1'b1;
      ev.char_code = b0[6:0];
    end else if (b0 == ESC_CODE && b1 == 8'd0) begin
      ev.pressed = 1'b1;
      ev.char_code = b0[6:0];
    end else if (b0 == ESC_CODE && b1 == CHR_LBRACK) begin
      ev.pressed = 1'b1;
      if (b2 == CHR_UP) begin
        ev.key_code = KC_UP;
      end else if (b2 == CHR_DOWN) begin
        ev.key_code = KC_DOWN;
      end else if (b2 == CHR_RIGHT) begin
        ev.key_code = KC_RIGHT;
      end else if (b2 == CHR_LEFT) begin
        ev.key_code = KC_LEFT;
      end else if (b2 == CHR_HOME) begin
        ev.key_code = KC_HOME;
      end else if (b2 == CHR_END) begin
        ev.key_code = KC_END;
      end else if (b2 >= CHR_ONE && b2 <= CHR_SIX && b3 == CHR_TILDE) begin
        ev.key_code = KC_HOME + tilde_ofs[3:0];
      end
    end
    return ev;
  endfunction

endpackage

### rtl/core/terminal_escape_key_decoder.sv
// A request that completes an event shows its result in the cycle after its acceptance.
// One request per cycle unless an untaken result stalls the input; the parser state and
// the result register are the only storage, and it frees as soon as its event is taken.
// Reset (synchronous, active high) returns the parser to plain state, clears the gathered
// bytes, length and idle count, drops the result, and sets the idle threshold to 2.
// Depends on tekd_pkg and terminal_escape_key_decoder_assert.svh.
`include "terminal_escape_key_decoder_assert.svh"

module terminal_escape_key_decoder import tekd_pkg::*; #(
  parameter int MAX_SEQ_LEN = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] char_code, [10:7] key_code, [15:11] zero
  output logic        m_axis_tuser    // [0] pressed
);

  localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);

  logic [7:0]       esc_idle_ticks;
  parse_state_t     parse_state, parse_state_next;
  logic [7:0]       seq_bytes [4];
  logic [7:0]       seq_bytes_next [4];
  logic [LEN_W-1:0] seq_length, seq_length_next;
  logic [7:0]       idle_count, idle_count_next;
  logic             out_valid;
  key_event_t       out_event;

  mode_t            req_mode;
  logic             req_accept;
  logic             keep_open;
  logic             emit;
  logic [LEN_W-1:0] len_inc;
  logic [7:0]       idle_inc;
  key_event_t       event_next;

  assign req_mode      = mode_t'(s_axis_tuser);
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign req_accept    = s_axis_tvalid && s_axis_tready;
  assign len_inc       = seq_length + LEN_W'(1);
  assign idle_inc      = (idle_count < IDLE_MAX) ? idle_count + 8'd1 : idle_count;

  // Next parser state, gathered bytes and counters for the request in flight.
  always_comb begin
    parse_state_next = parse_state;
    seq_length_next  = seq_length;
    idle_count_next  = idle_count;
    keep_open        = 1'b0;
    emit             = 1'b0;
    for (int i = 0; i < 4; i++) begin
      seq_bytes_next[i] = seq_bytes[i];
    end
    unique case (parse_state)
      ST_PLAIN: begin
        keep_open = (s_axis_tdata == ESC_CODE);
      end
      ST_ESC: begin
        keep_open = (s_axis_tdata == CHR_LBRACK);
      end
      ST_PARAM: begin
        keep_open = (s_axis_tdata >= PARAM_LO && s_axis_tdata <= PARAM_HI)
                 || (s_axis_tdata >= INTER_LO && s_axis_tdata <= INTER_HI);
      end
      ST_INTER: begin
        keep_open = (s_axis_tdata >= INTER_LO && s_axis_tdata <= INTER_HI);
      end
      default: begin
        keep_open = 1'b0;
      end
    endcase
    unique case (req_mode)
      MODE_DATA: begin
        idle_count_next = '0;
        if (seq_length < LEN_W'(4)) begin
          seq_bytes_next[seq_length[1:0]] = s_axis_tdata;
        end
        seq_length_next = len_inc;
        emit = !keep_open || (len_inc >= LEN_W'(MAX_SEQ_LEN));
        unique case (parse_state)
          ST_PLAIN: parse_state_next = ST_ESC;
          ST_ESC:   parse_state_next = ST_PARAM;
          ST_PARAM: begin
            if (!(s_axis_tdata >= PARAM_LO && s_axis_tdata <= PARAM_HI)) begin
              parse_state_next = ST_INTER;
            end
          end
          default:  parse_state_next = ST_INTER;
        endcase
      end
      MODE_IDLE: begin
        if (seq_length != '0) begin
          idle_count_next = idle_inc;
          emit = (idle_inc >= esc_idle_ticks);
        end
      end
      MODE_END: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (emit) begin
      parse_state_next = ST_PLAIN;
      seq_length_next  = '0;
      idle_count_next  = '0;
      for (int i = 0; i < 4; i++) begin
        seq_bytes_next[i] = '0;
      end
    end
  end

  // Event decoded from the first four bytes as they stand after this request.
  always_comb begin
    event_next = decode_keys(seq_bytes_next[0], seq_bytes_next[1],
                             seq_bytes_next[2], seq_bytes_next[3]);
    if (emit) begin
      event_next = decode_keys((req_mode == MODE_DATA && seq_length == '0) ? s_axis_tdata
                                 : seq_bytes[0],
                               (req_mode == MODE_DATA && seq_length == LEN_W'(1))
                                 ? s_axis_tdata : seq_bytes[1],
                               (req_mode == MODE_DATA && seq_length == LEN_W'(2))
                                 ? s_axis_tdata : seq_bytes[2],
                               (req_mode == MODE_DATA && seq_length == LEN_W'(3))
                                 ? s_axis_tdata : seq_bytes[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_idle_ticks <= IDLE_TICKS_RESET;
    end else if (cfg_we) begin
      esc_idle_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_PLAIN;
      seq_length  <= '0;
      idle_count  <= '0;
      for (int i = 0; i < 4; i++) begin
        seq_bytes[i] <= '0;
      end
    end else if (req_accept) begin
      parse_state <= parse_state_next;
      seq_length  <= seq_length_next;
      idle_count  <= idle_count_next;
      for (int i = 0; i < 4; i++) begin
        seq_bytes[i] <= seq_bytes_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_accept) begin
      out_valid <= emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept && emit) begin
      out_event <= event_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_event.pressed;
  assign m_axis_tdata  = {5'd0, out_event.key_code, out_event.char_code};

  `TEKD_ASSERT(a_idle_needs_seq, (idle_count != '0) |-> (seq_length != '0), "stray idle count")
  `TEKD_ASSERT(a_state_seq, (parse_state != ST_PLAIN) |-> (seq_length != '0), "open, no bytes")
  `TEKD_ASSERT_ALWAYS(a_len_bound, !rst |-> (seq_length < LEN_W'(MAX_SEQ_LEN)), "length overrun")
  `TEKD_ASSERT(a_end_evt, (req_accept && req_mode == MODE_END) |=> m_axis_tvalid, "no end event")
  `TEKD_ASSERT(a_unk, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "stray data")

endmodule

### tb/sv/terminal_escape_key_decoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for terminal_escape_key_decoder: directed and random byte, idle
// and end-of-input requests, with a scoreboard that predicts every key event in order.
// Depends on tekd_pkg and the decoder RTL only.

import tekd_pkg::*;

class key_event_scoreboard;
  localparam logic [3:0] KC_INSERT = 4'd6;
  localparam logic [3:0] KC_DELETE = 4'd7;
  localparam logic [3:0] KC_PGUP   = 4'd9;
  localparam logic [3:0] KC_PGDN   = 4'd10;

  logic [7:0]   idle_ticks;
  parse_state_t state;
  logic [7:0]   seq [4];
  int unsigned  seq_len;
  int unsigned  seq_limit;
  logic [7:0]   idle_cnt;
  logic [3:0]   tilde_key [6];
  key_event_t   expected_q [$];
  int unsigned  mismatches;

  function new(int unsigned limit);
    seq_limit = limit;
    idle_ticks = IDLE_TICKS_RESET;
    mismatches = 0;
    tilde_key = '{KC_HOME, KC_INSERT, KC_DELETE, KC_END, KC_PGUP, KC_PGDN};
    clear_sequence();
  endfunction

  function void clear_sequence();
    state = ST_PLAIN;
    foreach (seq[i]) seq[i] = 8'd0;
    seq_len = 0;
    idle_cnt = 8'd0;
  endfunction

  function void set_idle_ticks(logic [7:0] value);
    idle_ticks = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // The first four gathered bytes alone decide the event.
  function void close_sequence();
    key_event_t ev;
    ev = '0;
    if ((seq[0] >= PRINT_LO && seq[0] <= PRINT_HI) || (seq[0] >= 8'd1 && seq[0] <= CTRL_HI)) begin
      ev.pressed = 1'b1;
      ev.char_code = seq[0][6:0];
    end else if (seq[0] == ESC_CODE && seq[1] == 8'd0) begin
      ev.pressed = 1'b1;
      ev.char_code = seq[0][6:0];
    end else if (seq[0] == ESC_CODE && seq[1] == CHR_LBRACK) begin
      ev.pressed = 1'b1;
      case (seq[2])
        CHR_UP:    ev.key_code = KC_UP;
        CHR_DOWN:  ev.key_code = KC_DOWN;
        CHR_RIGHT: ev.key_code = KC_RIGHT;
        CHR_LEFT:  ev.key_code = KC_LEFT;
        CHR_HOME:  ev.key_code = KC_HOME;
        CHR_END:   ev.key_code = KC_END;
        default: begin
          if (seq[2] >= CHR_ONE && seq[2] <= CHR_SIX && seq[3] == CHR_TILDE) begin
            ev.key_code = tilde_key[int'(seq[2] - CHR_ONE)];
          end
        end
      endcase
    end
    expected_q.push_back(ev);
    clear_sequence();
  endfunction

  function bit stays_open(logic [7:0] c);
    case (state)
      ST_PLAIN: begin
        if (c == ESC_CODE) begin
          state = ST_ESC;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_ESC: begin
        if (c == CHR_LBRACK) begin
          state = ST_PARAM;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_PARAM: begin
        if (c >= PARAM_LO && c <= PARAM_HI) return 1'b1;
        state = ST_INTER;
        return c >= INTER_LO && c <= INTER_HI;
      end
      default: return c >= INTER_LO && c <= INTER_HI;
    endcase
  endfunction

  // Returns 1 when the request has any effect on the decoder.
  function bit note_request(logic [1:0] mode, logic [7:0] c);
    if (mode == MODE_DATA) begin
      idle_cnt = 8'd0;
      if (seq_len < 4) seq[seq_len] = c;
      seq_len++;
      if (!stays_open(c) || seq_len >= seq_limit) close_sequence();
      return 1'b1;
    end
    if (mode == MODE_IDLE) begin
      if (seq_len == 0) return 1'b0;
      if (idle_cnt < IDLE_MAX) idle_cnt++;
      if (idle_cnt >= idle_ticks) close_sequence();
      return 1'b1;
    end
    if (mode == MODE_END) begin
      close_sequence();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void check_event(logic pressed, logic [15:0] tdata);
    key_event_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected key event: pressed %0d tdata 0x%04h", pressed, tdata);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (pressed !== want.pressed) begin
      $error("pressed: expected %0d, actual %0d", want.pressed, pressed);
      mismatches++;
    end
    if (tdata[6:0] !== want.char_code) begin
      $error("char_code: expected %0d, actual %0d", want.char_code, tdata[6:0]);
      mismatches++;
    end
    if (tdata[10:7] !== want.key_code) begin
      $error("key_code: expected %0d, actual %0d", want.key_code, tdata[10:7]);
      mismatches++;
    end
    if (tdata[15:11] !== 5'd0) begin
      $error("tdata padding: expected 0, actual %0d", tdata[15:11]);
      mismatches++;
    end
  endfunction
endclass

module terminal_escape_key_decoder_test;
  localparam int SEQ_LIMIT = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 258;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_PHASE = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [7:0] PHASE_TICKS [NUM_PHASES] = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd3, 8'd7};
  localparam int PHASE_GAP [NUM_PHASES] = '{0, 76, 0, 32, 0, 76};
  localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 76, 32, 0, 76};
  localparam logic [7:0] KEY_FINALS [6] = '{CHR_UP, CHR_DOWN, CHR_RIGHT, CHR_LEFT,
                                            CHR_HOME, CHR_END};

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_start = 1'b0;
  int requests_done = 0;
  int quiet_cycles = 0;
  logic [7:0] cur_idle_ticks = IDLE_TICKS_RESET;

  key_event_scoreboard sb = new(SEQ_LIMIT);

  terminal_escape_key_decoder #(
    .MAX_SEQ_LEN(SEQ_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, or holds off for a long stretch when asked.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      hold_start = 1'b0;
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        if (sb.note_request(s_axis_tuser, s_axis_tdata)) requests_done++;
        quiet_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_event(m_axis_tuser, m_axis_tdata);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL terminal_escape_key_decoder");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic [7:0] c);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= c;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_events();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_idle_ticks(input logic [7:0] value);
    drain_events();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_idle_ticks(value);
    cur_idle_ticks = value;
  endtask

  task automatic send_idle_run();
    int n;
    int top;
    top = (cur_idle_ticks > 8'd6) ? 6 : int'(cur_idle_ticks);
    if ($urandom_range(9) == 0) n = (cur_idle_ticks == 8'd0) ? 1 : int'(cur_idle_ticks);
    else n = $urandom_range(1, top + 1);
    repeat (n) send_request(MODE_IDLE, 8'($urandom_range(255)));
  endtask

  task automatic run_directed();
    send_request(MODE_DATA, 8'h61);
    send_request(MODE_DATA, PRINT_HI);
    send_request(MODE_DATA, 8'h01);
    send_request(MODE_DATA, CTRL_HI);
    send_request(MODE_DATA, 8'h00);
    send_request(MODE_DATA, 8'h80);
    send_request(MODE_DATA, 8'hFF);
    send_request(MODE_IDLE, 8'h00);
    send_request(MODE_END, 8'hFF);
    send_request(MODE_UNUSED, 8'h5A);
    send_request(MODE_DATA, ESC_CODE);
    send_request(MODE_IDLE, 8'hA5);
    send_request(MODE_IDLE, 8'h00);
    send_request(MODE_DATA, ESC_CODE);
    send_request(MODE_DATA, CHR_LBRACK);
    send_request(MODE_DATA, CHR_UP);
    send_request(MODE_DATA, ESC_CODE);
    send_request(MODE_DATA, CHR_LBRACK);
    send_request(MODE_DATA, 8'(CHR_ONE + 8'd2));
    send_request(MODE_DATA, CHR_TILDE);
    send_request(MODE_DATA, ESC_CODE);
    send_request(MODE_DATA, 8'h78);
    send_request(MODE_DATA, ESC_CODE);
    send_request(MODE_END, 8'h00);
  endtask

  // Plain characters, well-formed escape sequences with random content, broken or overlong sequences and noise.
  task automatic send_random_unit();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(3) != 0) send_request(MODE_DATA, 8'($urandom_range(1, 127)));
      else send_request(MODE_DATA, 8'($urandom_range(255)));
    end else if (pick < 55) begin
      send_request(MODE_DATA, ESC_CODE);
      send_request(MODE_DATA, CHR_LBRACK);
      case ($urandom_range(2))
        0: begin
          if ($urandom_range(4) != 0) send_request(MODE_DATA, KEY_FINALS[$urandom_range(5)]);
          else send_request(MODE_DATA, 8'($urandom_range(8'h40, 8'h7E)));
        end
        1: begin
          if ($urandom_range(4) != 0) send_request(MODE_DATA, 8'(CHR_ONE + $urandom_range(5)));
          else send_request(MODE_DATA, 8'($urandom_range(PARAM_LO, PARAM_HI)));
          if ($urandom_range(4) != 0) send_request(MODE_DATA, CHR_TILDE);
          else send_request(MODE_DATA, 8'($urandom_range(INTER_LO, 8'h7E)));
        end
        default: begin
          n = $urandom_range(4);
          repeat (n) send_request(MODE_DATA, 8'($urandom_range(PARAM_LO, PARAM_HI)));
          n = $urandom_range(2);
          repeat (n) send_request(MODE_DATA, 8'($urandom_range(INTER_LO, INTER_HI)));
          send_request(MODE_DATA, 8'($urandom_range(8'h40, 8'h7E)));
        end
      endcase
    end else if (pick < 70) begin
      send_request(MODE_DATA, ESC_CODE);
      case ($urandom_range(2))
        0: send_idle_run();
        1: send_request(MODE_END, 8'($urandom_range(255)));
        default: send_request(MODE_DATA, 8'($urandom_range(255)));
      endcase
    end else if (pick < 80) begin
      send_request(MODE_DATA, ESC_CODE);
      send_request(MODE_DATA, CHR_LBRACK);
      if ($urandom_range(1) != 0) send_request(MODE_DATA, 8'(CHR_ONE + $urandom_range(5)));
      if ($urandom_range(1) != 0) send_idle_run();
      else send_request(MODE_END, 8'($urandom_range(255)));
    end else if (pick < 85) begin
      send_request(MODE_DATA, ESC_CODE);
      send_request(MODE_DATA, CHR_LBRACK);
      n = $urandom_range(12, 16);
      repeat (n) send_request(MODE_DATA, 8'($urandom_range(INTER_LO, PARAM_HI)));
    end else begin
      send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) write_idle_ticks(PHASE_TICKS[p]);
      gap_pct = PHASE_GAP[p];
      stall_pct = PHASE_STALL[p];
      if (p == HOLD_PHASE) hold_start = 1'b1;
      while (requests_done < (p + 1) * ITEMS_PER_PHASE) send_random_unit();
    end
    gap_pct = 0;
    stall_pct = 0;
    drain_events();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS terminal_escape_key_decoder");
    end else begin
      $display("FAIL terminal_escape_key_decoder");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/tekd_pkg.sv
rtl/core/terminal_escape_key_decoder.sv
tb/sv/terminal_escape_key_decoder_test.sv
